// ===== sv/sfr_pkg.sv =====
// ---------------------------------------------------------------------------
// sfr_pkg
// Shared types, event codes and constants of the framed receiver core.
// ---------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

    localparam int SFR_BUFFER_BYTES_DEF = 1024;
    localparam int SFR_HEADER_BYTES     = 8;

    localparam int SFR_BYTE_W  = 8;
    localparam int SFR_CMD_W   = 16;
    localparam int SFR_LEN_W   = 32;
    localparam int SFR_IDX_W   = 10;
    localparam int SFR_EV_W    = 3;
    localparam int SFR_CFG_IDX_W  = 2;
    localparam int SFR_CFG_DATA_W = 16;

    // result event codes
    localparam logic [SFR_EV_W-1:0] EV_IGNORED = 3'd0;
    localparam logic [SFR_EV_W-1:0] EV_HEADER  = 3'd1;
    localparam logic [SFR_EV_W-1:0] EV_ACCEPT  = 3'd2;
    localparam logic [SFR_EV_W-1:0] EV_REJECT  = 3'd3;
    localparam logic [SFR_EV_W-1:0] EV_PAYLOAD = 3'd4;
    localparam logic [SFR_EV_W-1:0] EV_GOOD    = 3'd5;
    localparam logic [SFR_EV_W-1:0] EV_BAD     = 3'd6;
    localparam logic [SFR_EV_W-1:0] EV_DROP    = 3'd7;

    // configuration register indexes
    localparam logic [SFR_CFG_IDX_W-1:0] CFG_FIRST_MARK  = 2'd0;
    localparam logic [SFR_CFG_IDX_W-1:0] CFG_SECOND_MARK = 2'd1;
    localparam logic [SFR_CFG_IDX_W-1:0] CFG_MAX_COMMAND = 2'd2;

    localparam logic [SFR_BYTE_W-1:0] FIRST_MARK_RST  = 8'h55;
    localparam logic [SFR_BYTE_W-1:0] SECOND_MARK_RST = 8'hAA;
    localparam logic [SFR_CMD_W-1:0]  MAX_COMMAND_RST = 16'hFFFF;

    typedef struct packed {
        logic [SFR_BYTE_W-1:0] first_mark;
        logic [SFR_BYTE_W-1:0] second_mark;
        logic [SFR_CMD_W-1:0]  max_command;
    } cfg_t;

    typedef struct packed {
        logic [SFR_EV_W-1:0]   event_res;
        logic [SFR_BYTE_W-1:0] data_byte;
        logic [SFR_IDX_W-1:0]  payload_index;
        logic [SFR_CMD_W-1:0]  command;
        logic [SFR_IDX_W-1:0]  length;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/sfr_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// sfr_cfg_regs
// Configuration registers: start marks and command limit, written by index.
// ---------------------------------------------------------------------------
`default_nettype none

module sfr_cfg_regs
    import sfr_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [SFR_CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [SFR_CFG_DATA_W-1:0] cfg_data,
    output cfg_t                           cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_FIRST_MARK:  cfg_next.first_mark  = cfg_data[SFR_BYTE_W-1:0];
                CFG_SECOND_MARK: cfg_next.second_mark = cfg_data[SFR_BYTE_W-1:0];
                CFG_MAX_COMMAND: cfg_next.max_command = cfg_data[SFR_CMD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.first_mark  <= FIRST_MARK_RST;
            cfg_reg.second_mark <= SECOND_MARK_RST;
            cfg_reg.max_command <= MAX_COMMAND_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/sfr_frame_step.sv =====
// ---------------------------------------------------------------------------
// sfr_frame_step
// Frame state (byte count, running sum, header fields) and the per-byte
// decision logic that produces one result for each received byte.
// ---------------------------------------------------------------------------
`default_nettype none

module sfr_frame_step
    import sfr_pkg::*;
#(
    parameter int BUFFER_BYTES = SFR_BUFFER_BYTES_DEF
)(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  step_en,
    input  wire logic [SFR_BYTE_W-1:0] rx_byte,
    input  cfg_t                       cfg,
    output result_t                    res
);

    localparam int CW = $clog2(BUFFER_BYTES + 1);

    logic [CW-1:0]         count_reg,  count_next;
    logic [SFR_BYTE_W-1:0] sum_reg,    sum_next;
    logic [SFR_CMD_W-1:0]  cmd_reg,    cmd_next;
    logic [SFR_LEN_W-1:0]  len_reg,    len_next;

    logic [CW-1:0]         cnt_inc;
    logic [CW:0]           end_mark;
    logic [CW+9:0]         pos_ext;
    logic                  show_hdr;

    assign cnt_inc  = count_reg + CW'(1);
    // incremented count value at which the checksum byte arrives
    assign end_mark = (CW+1)'(len_reg[CW-1:0]) + (CW+1)'(SFR_HEADER_BYTES + 1);
    assign pos_ext  = (CW+10)'(count_reg) - (CW+10)'(SFR_HEADER_BYTES);

    always_comb begin
        count_next        = count_reg;
        sum_next          = sum_reg;
        cmd_next          = cmd_reg;
        len_next          = len_reg;
        show_hdr          = 1'b0;
        res.event_res     = EV_IGNORED;
        res.data_byte     = rx_byte;
        res.payload_index = '0;

        if (count_reg == '0) begin
            if (rx_byte == cfg.first_mark) begin
                sum_next      = cfg.first_mark;
                count_next    = CW'(1);
                res.event_res = EV_HEADER;
            end
        end else if (count_reg == CW'(1)) begin
            // a wrong byte here keeps waiting for the second mark
            if (rx_byte == cfg.second_mark) begin
                sum_next      = sum_reg + cfg.second_mark;
                count_next    = CW'(2);
                res.event_res = EV_HEADER;
            end
        end else if (count_reg < CW'(SFR_HEADER_BYTES)) begin
            if (count_reg < CW'(4)) begin
                cmd_next = {cmd_reg[SFR_CMD_W-SFR_BYTE_W-1:0], rx_byte};
            end else begin
                len_next = {len_reg[SFR_LEN_W-SFR_BYTE_W-1:0], rx_byte};
            end
            sum_next      = sum_reg + rx_byte;
            count_next    = cnt_inc;
            res.event_res = EV_HEADER;
            if (cnt_inc == CW'(SFR_HEADER_BYTES)) begin
                show_hdr = 1'b1;
                if (len_next < SFR_LEN_W'(BUFFER_BYTES) && cmd_next <= cfg.max_command) begin
                    res.event_res = EV_ACCEPT;
                end else begin
                    res.event_res = EV_REJECT;
                    count_next    = '0;
                    sum_next      = '0;
                end
            end
        end else if (count_reg < CW'(BUFFER_BYTES)) begin
            show_hdr   = 1'b1;
            count_next = cnt_inc;
            if ({1'b0, cnt_inc} >= end_mark) begin
                res.event_res = (sum_reg == rx_byte) ? EV_GOOD : EV_BAD;
                count_next    = '0;
                sum_next      = '0;
            end else begin
                sum_next          = sum_reg + rx_byte;
                res.event_res     = EV_PAYLOAD;
                res.payload_index = pos_ext[SFR_IDX_W-1:0];
            end
        end else begin
            show_hdr      = 1'b1;
            res.event_res = EV_DROP;
            count_next    = '0;
            sum_next      = '0;
        end

        res.command = show_hdr ? cmd_next : '0;
        res.length  = show_hdr ? len_next[SFR_IDX_W-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            sum_reg   <= '0;
            cmd_reg   <= '0;
            len_reg   <= '0;
        end else if (step_en) begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            cmd_reg   <= cmd_next;
            len_reg   <= len_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/sync_frame_receiver_checksum_core.sv =====
// ---------------------------------------------------------------------------
// sync_frame_receiver_checksum_core
// Start-mark framed receiver with 8-bit additive checksum, one byte a cycle unless m_ stalls.
// ---------------------------------------------------------------------------
// Usage:
//   s_ channel carries one received serial byte per transfer. Each byte gives
//   exactly one result transfer on the m_ channel: an event code on m_tuser
//   and the byte, payload index, command and length on m_tdata.
//   cfg channel writes first_mark (0), second_mark (1), max_command (2); it is
//   always ready and should be written only while no byte is in flight.
// Path: an accepted byte is registered in the input register, then decoded
//   into the output register once that is free or being taken, and offered
//   on m_ from the output register.
// Throughput: one byte per cycle while m_ is not stalled; the byte decode
//   is a few compares and an 8-bit add between the input and output registers.
// Reset: frame state returns to hunting for the first mark, the marks and
//   command limit return to 0x55, 0xAA and 0xFFFF, both stages empty.
// Stall: while m_tready is low the result holds; the input register still
//   takes a byte if it is empty, then s_tready drops until the result is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module sync_frame_receiver_checksum_core
    import sfr_pkg::*;
#(
    parameter int BUFFER_BYTES = SFR_BUFFER_BYTES_DEF
)(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // input byte stream
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [7:0]                s_tdata,   // [7:0] rx_byte
    // result stream
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [47:0]                    m_tdata,   // [7:0] data_byte, [17:8] payload_index,
                                                      // [33:18] command, [43:34] length
    output logic [2:0]                     m_tuser,   // [2:0] event_res
    // configuration writes
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [SFR_CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [SFR_CFG_DATA_W-1:0] cfg_data
);

    cfg_t                  cfg;
    result_t               step_res;

    logic                  in_valid_reg;
    logic [SFR_BYTE_W-1:0] in_byte_reg;
    logic                  out_valid_reg;
    result_t               out_res_reg;
    logic                  advance;

    // the registered byte moves on whenever the output slot is free or leaving
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    sfr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sfr_frame_step #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .rx_byte (in_byte_reg),
        .cfg     (cfg),
        .res     (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
        if (advance) begin
            out_res_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.event_res;
    assign m_tdata  = {4'b0000, out_res_reg.length, out_res_reg.command,
                       out_res_reg.payload_index, out_res_reg.data_byte};

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |-> !advance)
        else $error("result overwritten while stalled");

    a_in_captured: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> in_valid_reg)
        else $error("accepted byte not held in input register");

    a_index_only_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_res_reg.event_res != EV_PAYLOAD)
            |-> out_res_reg.payload_index == '0)
        else $error("payload index on non-payload event");

    a_hdr_hidden: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_res_reg.event_res == EV_IGNORED
                           || out_res_reg.event_res == EV_HEADER))
            |-> (out_res_reg.command == '0 && out_res_reg.length == '0))
        else $error("header fields shown before header complete");

endmodule

`default_nettype wire

// ===== tb/sync_frame_receiver_checksum_core_tb.sv =====
// ---------------------------------------------------------------------------
// sync_frame_receiver_checksum_core_tb
// Self-checking bench for the start-mark framed receiver. A short table of
// bytes covers mark hunting, header accept and reject and one full frame.
// It is followed by randomized frames, noise, truncated and rejected headers
// and a few oversized frames, over several mark and command-limit settings.
// Results are checked with typed table rows or a cycle-free decoder model.
// ---------------------------------------------------------------------------
`default_nettype none

module sync_frame_receiver_checksum_core_tb;
    import sfr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUF_BYTES = SFR_BUFFER_BYTES_DEF;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [SFR_CFG_IDX_W-1:0]  cfg_index;
    logic [SFR_CFG_DATA_W-1:0] cfg_data;

    sync_frame_receiver_checksum_core #(
        .BUFFER_BYTES(BUF_BYTES)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // decoder model state
    cfg_t        cfg;
    logic [10:0] byte_cnt;
    logic [7:0]  run_sum;
    logic [15:0] frm_cmd;
    logic [31:0] frm_len;

    result_t events_due[$];
    int      fail_cnt   = 0;
    int      live_items = 0;
    int      s_idle     = 22;
    int      r_idle     = 68;

    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        result_t    res;
    } byte_row_t;

    byte_row_t byte_rows [22] = '{
        '{8'h00, 1'b1, '{EV_IGNORED, 8'h00, 10'd0, 16'h0000, 10'd0}},
        '{8'h55, 1'b1, '{EV_HEADER,  8'h55, 10'd0, 16'h0000, 10'd0}},
        // repeated first mark, then a wrong second byte
        '{8'h55, 1'b1, '{EV_IGNORED, 8'h55, 10'd0, 16'h0000, 10'd0}},
        '{8'h13, 1'b1, '{EV_IGNORED, 8'h13, 10'd0, 16'h0000, 10'd0}},
        '{8'hAA, 1'b1, '{EV_HEADER,  8'hAA, 10'd0, 16'h0000, 10'd0}},
        '{8'h00, 1'b0, '0},
        '{8'h07, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h02, 1'b1, '{EV_ACCEPT,  8'h02, 10'd0, 16'h0007, 10'd2}},
        '{8'h00, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'h07, 1'b0, '0},
        // all-ones header: length too wide, only low bits show
        '{8'h55, 1'b0, '0},
        '{8'hAA, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b1, '{EV_REJECT,  8'hFF, 10'd0, 16'hFFFF, 10'h3FF}}
    };

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic result_t decode_byte(input logic [7:0] b);
        result_t     r;
        logic        show;
        logic [10:0] pos;
        r           = '0;
        r.data_byte = b;
        r.event_res = EV_IGNORED;
        show        = 1'b0;
        if (byte_cnt == 0) begin
            if (b == cfg.first_mark) begin
                run_sum     = cfg.first_mark;
                byte_cnt    = 11'd1;
                r.event_res = EV_HEADER;
            end
        end else if (byte_cnt == 1) begin
            if (b == cfg.second_mark) begin
                run_sum     = run_sum + cfg.second_mark;
                byte_cnt    = 11'd2;
                r.event_res = EV_HEADER;
            end
        end else if (byte_cnt < SFR_HEADER_BYTES) begin
            if (byte_cnt < 4)
                frm_cmd = {frm_cmd[7:0], b};
            else
                frm_len = {frm_len[23:0], b};
            run_sum     = run_sum + b;
            byte_cnt    = byte_cnt + 11'd1;
            r.event_res = EV_HEADER;
            if (byte_cnt == SFR_HEADER_BYTES) begin
                show = 1'b1;
                if (frm_len < BUF_BYTES && frm_cmd <= cfg.max_command) begin
                    r.event_res = EV_ACCEPT;
                end else begin
                    r.event_res = EV_REJECT;
                    byte_cnt    = '0;
                    run_sum     = '0;
                end
            end
        end else if (byte_cnt < BUF_BYTES) begin
            pos      = byte_cnt - SFR_HEADER_BYTES;
            show     = 1'b1;
            byte_cnt = byte_cnt + 11'd1;
            if ({21'd0, byte_cnt} >= frm_len + 32'd9) begin
                // checksum byte closes the frame
                r.event_res = (run_sum == b) ? EV_GOOD : EV_BAD;
                byte_cnt    = '0;
                run_sum     = '0;
            end else begin
                run_sum         = run_sum + b;
                r.event_res     = EV_PAYLOAD;
                r.payload_index = pos[9:0];
            end
        end else begin
            show        = 1'b1;
            r.event_res = EV_DROP;
            byte_cnt    = '0;
            run_sum     = '0;
        end
        if (show) begin
            r.command = frm_cmd;
            r.length  = frm_len[9:0];
        end
        return r;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic typed, input result_t res);
        result_t r;
        while ($urandom_range(0, 99) < s_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = decode_byte(b);
        if (r.event_res != EV_IGNORED) live_items++;
        events_due.push_back(typed ? res : r);
    endtask

    // sender holds off until every result is back, so the core is idle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (events_due.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [SFR_CFG_IDX_W-1:0] idx,
                             input logic [SFR_CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_FIRST_MARK:  cfg.first_mark  = data[7:0];
            CFG_SECOND_MARK: cfg.second_mark = data[7:0];
            CFG_MAX_COMMAND: cfg.max_command = data;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] fm, input logic [7:0] sm,
                              input logic [15:0] mc);
        // upper data bits of the mark writes are junk on purpose
        write_reg(CFG_FIRST_MARK,  {8'($urandom), fm});
        write_reg(CFG_SECOND_MARK, {8'($urandom), sm});
        write_reg(CFG_MAX_COMMAND, mc);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_frame(input logic [31:0] len, input logic [15:0] cmd,
                              input logic bad_sum, input logic junk);
        logic [7:0] fr[$];
        logic [7:0] sum;
        logic [7:0] j;
        fr = '{cfg.first_mark};
        j  = '0;
        if (junk) begin
            j = 8'($urandom);
            if (j == cfg.second_mark) j = ~j;
            fr.push_back(j);
        end
        fr.push_back(cfg.second_mark);
        fr.push_back(cmd[15:8]);
        fr.push_back(cmd[7:0]);
        fr.push_back(len[31:24]);
        fr.push_back(len[23:16]);
        fr.push_back(len[15:8]);
        fr.push_back(len[7:0]);
        if (len < BUF_BYTES && cmd <= cfg.max_command) begin
            repeat (len) fr.push_back(8'($urandom));
            sum = '0;
            foreach (fr[i]) sum = sum + fr[i];
            sum = sum - j;
            if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
            fr.push_back(sum);
        end
        foreach (fr[i]) send_byte(fr[i], 1'b0, '0);
    endtask

    task automatic random_step();
        logic [31:0] len;
        logic [15:0] cmd;
        int          k;
        k = $urandom_range(0, 99);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, '0);
        case ($urandom_range(0, 3))
            0:       cmd = cfg.max_command;
            1:       cmd = '0;
            default: cmd = 16'($urandom_range(0, cfg.max_command));
        endcase
        case ($urandom_range(0, 19))
            0:       len = 0;
            1:       len = $urandom_range(16, 64);
            default: len = $urandom_range(1, 8);
        endcase
        if (k < 65) begin
            send_frame(len, cmd, $urandom_range(0, 4) == 0, $urandom_range(0, 9) == 0);
        end else if (k < 75) begin
            case ($urandom_range(0, 3))
                0:       len = BUF_BYTES;
                1:       len = 32'hFFFF_FFFF;
                default: len = $urandom | 32'h400;
            endcase
            send_frame(len, cmd, 1'b0, 1'b0);
        end else if (k < 85 && cfg.max_command != 16'hFFFF) begin
            cmd = 16'($urandom_range(cfg.max_command + 1, 16'hFFFF));
            send_frame(len, cmd, 1'b0, 1'b0);
        end else begin
            // truncated frame, may leave the decoder mid-header or mid-payload
            send_byte(cfg.first_mark, 1'b0, '0);
            send_byte(cfg.second_mark, 1'b0, '0);
            repeat ($urandom_range(0, 8)) send_byte(8'($urandom), 1'b0, '0);
        end
    endtask

    // result side: random backpressure
    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            @(posedge aclk);
            m_tready <= ($urandom_range(0, 99) >= r_idle);
        end
    end

    always @(posedge aclk) begin : result_mon
        result_t want;
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tuser, m_tdata[7:0], m_tdata[17:8], m_tdata[33:18], m_tdata[43:34]};
            if (events_due.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display("unexpected result transfer: ev=%0d byte=%h", m_tuser, m_tdata[7:0]);
            end else begin
                want = events_due.pop_front();
                if (got !== want || m_tdata[47:44] !== 4'd0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("mismatch: exp ev=%0d byte=%h idx=%0d cmd=%h len=%0d | got ev=%0d byte=%h idx=%0d cmd=%h len=%0d pad=%h",
                                 want.event_res, want.data_byte, want.payload_index,
                                 want.command, want.length,
                                 got.event_res, got.data_byte, got.payload_index,
                                 got.command, got.length, m_tdata[47:44]);
                end
            end
        end
    end

    initial begin
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_FIRST_MARK;
        cfg_data  <= '0;
        aresetn   <= 1'b0;
        cfg.first_mark  = FIRST_MARK_RST;
        cfg.second_mark = SECOND_MARK_RST;
        cfg.max_command = MAX_COMMAND_RST;
        byte_cnt = '0;
        run_sum  = '0;
        frm_cmd  = '0;
        frm_len  = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (byte_rows[i])
            send_byte(byte_rows[i].rx, byte_rows[i].typed, byte_rows[i].res);

        for (int p = 0; p < 6; p++) begin
            wait_drained();
            case (p / 2)
                0:       begin s_idle = 22; r_idle = 68; end
                1:       begin s_idle = 68; r_idle = 22; end
                default: begin s_idle = 0;  r_idle = 0;  end
            endcase
            case (p)
                0: set_config(FIRST_MARK_RST, SECOND_MARK_RST, MAX_COMMAND_RST);
                1: set_config(8'h00, 8'hFF, 16'h0000);
                2: set_config(8'hFF, 8'h00, 16'h8000);
                3: set_config(8'($urandom), 8'($urandom), 16'($urandom));
                4: begin
                    // same byte for both marks
                    logic [7:0] mk;
                    mk = 8'($urandom);
                    set_config(mk, mk, 16'($urandom));
                end
                default: set_config(8'($urandom), 8'($urandom), 16'hFFFF);
            endcase
            // longest frame that fits, then frames that overrun the buffer
            case (p)
                0: send_frame(BUF_BYTES - SFR_HEADER_BYTES - 1, 16'h0001, 1'b0, 1'b0);
                2: send_frame(BUF_BYTES - SFR_HEADER_BYTES, 16'h0123, 1'b0, 1'b0);
                4: send_frame(BUF_BYTES - 1, 16'($urandom_range(0, cfg.max_command)),
                              1'b0, 1'b0);
                default: ;
            endcase
            live_items = 0;
            while (live_items < 100) random_step();
        end

        wait_drained();
        repeat (4) @(posedge aclk);
        if (fail_cnt == 0 && events_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sync_frame_receiver_checksum_core.f =====
sv/sfr_pkg.sv
sv/sfr_cfg_regs.sv
sv/sfr_frame_step.sv
sv/sync_frame_receiver_checksum_core.sv
tb/sync_frame_receiver_checksum_core_tb.sv
